// ===== rtl/core/sort_then_binary_search_macros.svh =====
// ----------------------------------------------------------------------------
// Sort-then-search assertion macros
// Shared concurrent assertion forms for the checker of the block.
// ----------------------------------------------------------------------------
`ifndef SORT_THEN_BINARY_SEARCH_MACROS_SVH
`define SORT_THEN_BINARY_SEARCH_MACROS_SVH

// Check on every clock edge outside reset.
`define STBS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define STBS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg
// Types and codes shared by the sort-then-search controller and datapath.
// ----------------------------------------------------------------------------
package stbs_pkg;

	localparam int unsigned VAL_W = 32;
	localparam int unsigned POS_W = 6;

	// Operation codes of an input item
	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_SEARCH = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	// Datapath commands issued by the controller
	typedef enum logic [3:0] {
		CMD_NONE       = 4'd0,
		CMD_ACCEPT     = 4'd1,
		CMD_PASS_LOAD  = 4'd2,
		CMD_PASS_FIRST = 4'd3,
		CMD_PASS_STEP  = 4'd4,
		CMD_PASS_END   = 4'd5,
		CMD_SRCH_CHK   = 4'd6,
		CMD_SRCH_CMP   = 4'd7
	} dp_cmd_t;

	// Datapath status back to the controller
	typedef struct packed {
		logic few_elems;   // fewer than two elements stored
		logic step_last;   // current compare-swap closes the pass
		logic sort_more;   // another pass follows this one
		logic range_open;  // search range not yet empty
		logic key_hit;     // probed element equals the key
	} dp_status_t;

endpackage

// ===== rtl/core/sort_then_binary_search.sv =====
// ----------------------------------------------------------------------------
// sort_then_binary_search
// Element store with in-place bubble sort and binary search on request.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. operation selects
//   append (value is stored if fewer than DEPTH elements are held), search
//   (value is the key) or clear. Unused codes are ignored.
//   Append and clear finish in the accepting cycle; busy stays low and no
//   result follows.
//   A search raises busy, sorts the stored elements ascending in place, then
//   probes the sorted array. The result (found, position) shows for exactly
//   one cycle with done high; busy drops in the cycle after done.
//   A search sorts first (no sort when fewer than two elements are stored),
//   then takes a check and a compare per probe, one final check when the key
//   is missing, and the done cycle.
//   The element memory takes one read and one write per cycle, which limits
//   the sort to one compare-swap per cycle.
//   The receiver cannot stall; done is a one-cycle strobe.
//   Reset empties the store; element contents are not cleared.
// ----------------------------------------------------------------------------
module sort_then_binary_search #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  operation,
	input  logic signed [31:0]          value,
	output logic                        done,
	output logic                        found,
	output logic [stbs_pkg::POS_W-1:0]  position
);
	import stbs_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	stbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	stbs_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operation (operation),
		.value     (value),
		.status    (status),
		.found     (found),
		.position  (position)
	);

endmodule

// ===== rtl/core/stbs_dp.sv =====
// ----------------------------------------------------------------------------
// stbs_dp
// Element memory, counters and compare logic for sort and binary search.
// ----------------------------------------------------------------------------
module stbs_dp #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  stbs_pkg::dp_cmd_t            cmd,
	input  logic [1:0]                   operation,
	input  logic signed [31:0]           value,
	output stbs_pkg::dp_status_t         status,
	output logic                         found,
	output logic [stbs_pkg::POS_W-1:0]   position
);
	import stbs_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned EW = AW + POS_W;

	logic signed [VAL_W-1:0] mem [DEPTH];
	logic signed [VAL_W-1:0] rdata_q;
	logic signed [VAL_W-1:0] carry_q;
	logic signed [VAL_W-1:0] key_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           lo_q;
	logic [CW-1:0]           hi_q;
	logic [AW-1:0]           i_q;
	logic [AW-1:0]           j_q;
	logic [AW-1:0]           mid_q;
	logic                    found_q;
	logic [POS_W-1:0]        pos_q;

	logic                    we;
	logic [AW-1:0]           waddr;
	logic [AW-1:0]           raddr;
	logic signed [VAL_W-1:0] wdata;
	logic                    full;
	logic                    swap;
	logic [CW-1:0]           cnt_m1;
	logic [CW:0]             mid_sum;
	logic [CW-1:0]           mid;
	logic [EW-1:0]           mid_ext;

	assign full    = (count_q == CW'(DEPTH));
	assign swap    = (rdata_q > carry_q);
	assign cnt_m1  = count_q - CW'(1);
	assign mid_sum = (CW+1)'(lo_q) + (CW+1)'(hi_q);
	assign mid     = mid_sum[CW:1];
	assign mid_ext = EW'(mid_q);

	assign status.few_elems  = (count_q < CW'(2));
	assign status.step_last  = (j_q == i_q + AW'(1));
	assign status.sort_more  = ((CW+1)'(i_q) + (CW+1)'(2) < (CW+1)'(count_q));
	assign status.range_open = (lo_q < hi_q);
	assign status.key_hit    = (key_q == rdata_q);

	assign found    = found_q;
	assign position = pos_q;

	always_comb begin
		we    = 1'b0;
		waddr = j_q;
		wdata = carry_q;
		raddr = j_q;
		unique case (cmd)
			CMD_ACCEPT: begin
				if (operation == OP_APPEND && !full) begin
					we    = 1'b1;
					waddr = count_q[AW-1:0];
					wdata = value;
				end
			end
			CMD_PASS_LOAD:  raddr = cnt_m1[AW-1:0];
			CMD_PASS_FIRST: raddr = j_q - AW'(1);
			CMD_PASS_STEP: begin
				// larger value settles at j, smaller one rides down in carry
				we    = 1'b1;
				waddr = j_q;
				wdata = swap ? rdata_q : carry_q;
				raddr = j_q - AW'(2);
			end
			CMD_PASS_END: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = carry_q;
			end
			CMD_SRCH_CHK: raddr = mid[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd == CMD_ACCEPT) begin
			if (operation == OP_APPEND && !full) begin
				count_q <= count_q + CW'(1);
			end else if (operation == OP_CLEAR) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_ACCEPT: begin
				if (operation == OP_SEARCH) begin
					key_q <= value;
					i_q   <= '0;
					lo_q  <= '0;
					hi_q  <= count_q;
				end
			end
			CMD_PASS_LOAD:  j_q <= cnt_m1[AW-1:0];
			CMD_PASS_FIRST: carry_q <= rdata_q;
			CMD_PASS_STEP: begin
				j_q <= j_q - AW'(1);
				if (!swap) begin
					carry_q <= rdata_q;
				end
			end
			CMD_PASS_END: i_q <= i_q + AW'(1);
			CMD_SRCH_CHK: begin
				mid_q <= mid[AW-1:0];
				if (!status.range_open) begin
					found_q <= 1'b0;
					pos_q   <= '0;
				end
			end
			CMD_SRCH_CMP: begin
				if (status.key_hit) begin
					found_q <= 1'b1;
					pos_q   <= mid_ext[POS_W-1:0];
				end else if (key_q < rdata_q) begin
					hi_q <= CW'(mid_q);
				end else begin
					lo_q <= CW'(mid_q) + CW'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/stbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for sort passes, binary-search probes and the result strobe.
// ----------------------------------------------------------------------------
module stbs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            operation,
	input  stbs_pkg::dp_status_t  status,
	output stbs_pkg::dp_cmd_t     cmd,
	output logic                  busy,
	output logic                  done
);
	import stbs_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE       = 8'b0000_0001,
		S_PASS_LOAD  = 8'b0000_0010,
		S_PASS_FIRST = 8'b0000_0100,
		S_PASS_STEP  = 8'b0000_1000,
		S_PASS_END   = 8'b0001_0000,
		S_SRCH_CHK   = 8'b0010_0000,
		S_SRCH_CMP   = 8'b0100_0000,
		S_REPORT     = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_REPORT);

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd = CMD_ACCEPT;
					if (operation == OP_SEARCH) begin
						state_d = status.few_elems ? S_SRCH_CHK : S_PASS_LOAD;
					end
				end
			end
			S_PASS_LOAD: begin
				cmd     = CMD_PASS_LOAD;
				state_d = S_PASS_FIRST;
			end
			S_PASS_FIRST: begin
				cmd     = CMD_PASS_FIRST;
				state_d = S_PASS_STEP;
			end
			S_PASS_STEP: begin
				cmd = CMD_PASS_STEP;
				if (status.step_last) begin
					state_d = S_PASS_END;
				end
			end
			S_PASS_END: begin
				cmd     = CMD_PASS_END;
				state_d = status.sort_more ? S_PASS_LOAD : S_SRCH_CHK;
			end
			S_SRCH_CHK: begin
				cmd     = CMD_SRCH_CHK;
				state_d = status.range_open ? S_SRCH_CMP : S_REPORT;
			end
			S_SRCH_CMP: begin
				cmd     = CMD_SRCH_CMP;
				state_d = status.key_hit ? S_REPORT : S_SRCH_CHK;
			end
			S_REPORT: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/stbs_chk.sv =====
// ----------------------------------------------------------------------------
// stbs_chk
// Port-level checks of the sort-then-search block, bound to the top level.
// ----------------------------------------------------------------------------
`include "sort_then_binary_search_macros.svh"

module stbs_chk (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [1:0]                  operation,
	input  logic                        done,
	input  logic                        found,
	input  logic [stbs_pkg::POS_W-1:0]  position
);
	import stbs_pkg::*;

	logic take_search;
	logic take_other;
	logic miss_seen;

	assign take_search = start && !busy && (operation == OP_SEARCH);
	assign take_other  = start && !busy && (operation != OP_SEARCH);
	assign miss_seen   = arst_n && done && !found;

	`STBS_ASSERT(a_done_while_busy, done |-> busy, "result strobe outside a search")
	`STBS_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")
	`STBS_ASSERT(a_search_busy, take_search |=> busy, "search item did not raise busy")
	`STBS_ASSERT(a_quick_items, take_other |=> (!busy && !done), "quick item caused work")
	`STBS_ASSERT_ALWAYS(a_miss_zero, miss_seen |-> (position == '0), "miss with nonzero position")

endmodule

bind sort_then_binary_search stbs_chk u_stbs_chk (.*);
